>>> src/fsad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsad_pkg: shared types and constants of the five-symbol arithmetic decoder
// Opcodes, status codes, item layouts, the front-to-back command and the
// fixed-point limits of the probability sum check.
// ----------------------------------------------------------------------------
package fsad_pkg;

    localparam int PAYLOAD_BYTES = 4096;
    localparam int PAYLOAD_AW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int NUM_SYMS      = 5;
    localparam int FREQ_BITS     = 31;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    // exact sum of five floats: 149 fraction bits, up to five units
    localparam int ACC_W   = 152;
    localparam int FRAC_LO = 118;   // term bit of weight 2^-31

    localparam logic [62:0] TOP     = {63{1'b1}};
    localparam logic [62:0] HALF    = 63'h4000_0000_0000_0000;
    localparam logic [62:0] QUARTER = 63'h2000_0000_0000_0000;
    localparam logic [31:0] PROB_MAX_BITS = 32'h3F80_00A7;

    // 0.99998 and 1.00002 as binary64, scaled by 2^53
    localparam logic [63:0] Q48 = (64'd1 << 48) / 64'd3125;
    localparam logic [63:0] R48 = (64'd1 << 48) % 64'd3125;
    localparam logic [63:0] Q47 = (64'd1 << 47) / 64'd3125;
    localparam logic [63:0] R47 = (64'd1 << 47) % 64'd3125;
    localparam logic [63:0] T_LOW  = 64'd99998 * Q48 + (64'd99998 * R48 + 64'd1562) / 64'd3125;
    localparam logic [63:0] T_HIGH =
        64'd2 * (64'd100002 * Q47 + (64'd100002 * R47 + 64'd1562) / 64'd3125);
    localparam logic [ACC_W-1:0] LIM_LOW  = ACC_W'(T_LOW) << 96;
    localparam logic [ACC_W-1:0] LIM_HIGH = ACC_W'(T_HIGH) << 96;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DECODE = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STATE    = 3'd1,
        ST_PROB     = 3'd2,
        ST_FREQ     = 3'd3,
        ST_INTERVAL = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [31:0] prob_zero;
        logic [31:0] prob_one;
        logic [31:0] prob_two;
        logic [31:0] prob_three;
        logic [31:0] prob_four;
        logic [62:0] load_low;
        logic [62:0] load_high;
        logic [62:0] load_code;
        logic [31:0] load_position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  symbol;
        logic [2:0]  status;
        logic [62:0] state_low;
        logic [62:0] state_high;
        logic [62:0] state_code;
        logic [31:0] state_position;
    } t_out_item;

    typedef logic [NUM_SYMS-1:0][FREQ_BITS-1:0] t_freqs;

    // classified item handed from front to back
    typedef struct packed {
        t_opcode     op;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [62:0] load_low;
        logic [62:0] load_high;
        logic [62:0] load_code;
        logic [31:0] load_position;
        t_freqs      freqs;
        t_status     cls;
    } t_cmd;

endpackage

>>> src/fsad_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsad_if: item channels of the decoder
// Valid/ready channels carrying one input item or one result item.
// ----------------------------------------------------------------------------
interface fsad_in_if;
    import fsad_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fsad_out_if;
    import fsad_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/fsad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsad_front: item intake and probability classification
// Takes items, and for decode items checks the five probabilities one per
// cycle, sums them exactly, builds the frequencies and classifies the item.
// ----------------------------------------------------------------------------
module fsad_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsad_in_if.sink       i_item,
    output logic          o_push,
    output fsad_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import fsad_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SCAN = 4'b0010,
        F_EVAL = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate                    r_state, n_state;
    t_in_item                   r_item;
    t_cmd                       r_cmd;
    logic [2:0]                 r_idx;
    logic [ACC_W-1:0]           r_acc;
    logic [NUM_SYMS-1:0][31:0]  r_freq;
    logic [34:0]                r_fsum;
    logic [2:0]                 r_win;
    logic [31:0]                r_win_bits;
    logic                       r_bad;

    logic [NUM_SYMS-1:0][31:0]  probs;
    logic [31:0]                bits;
    logic                       bad_now;
    logic [7:0]                 expo;
    logic [23:0]                sig;
    logic [7:0]                 sh;
    logic [ACC_W-1:0]           term;
    logic [31:0]                f_raw;
    logic [31:0]                freq_now;
    logic                       acc_bad;
    logic signed [35:0]         adj;
    logic                       adj_bad;
    logic                       other_bad;
    t_freqs                     freqs_fix;

    assign probs = {r_item.prob_four, r_item.prob_three, r_item.prob_two,
                    r_item.prob_one, r_item.prob_zero};

    // one probability: validity, exact term and truncated frequency
    always_comb begin
        bits     = probs[r_idx];
        bad_now  = (bits == 32'd0) || (bits > PROB_MAX_BITS);
        expo     = bits[30:23];
        sig      = {expo != 8'd0, bits[22:0]};
        sh       = (expo != 8'd0) ? expo - 8'd1 : 8'd0;
        term     = bad_now ? '0 : (ACC_W'(sig) << sh);
        f_raw    = term[FRAC_LO+31:FRAC_LO];
        freq_now = (f_raw == 32'd0) ? 32'd1 : f_raw;
    end

    // sum window check and remainder adjustment of the first maximum
    always_comb begin
        acc_bad   = r_bad || (r_acc < LIM_LOW) || (r_acc > LIM_HIGH);
        adj       = signed'({4'd0, r_freq[r_win]}) + 36'sd2147483648
                    - signed'({1'b0, r_fsum});
        adj_bad   = (adj <= 36'sd0) || (adj >= 36'sd2147483648);
        other_bad = 1'b0;
        for (int s = 0; s < NUM_SYMS; s++) begin
            if (3'(s) == r_win) begin
                freqs_fix[s] = adj[FREQ_BITS-1:0];
            end else begin
                freqs_fix[s] = r_freq[s][FREQ_BITS-1:0];
                if (r_freq[s][31]) begin
                    other_bad = 1'b1;
                end
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_item.valid) begin
                    n_state = (i_item.data.opcode == OP_DECODE) ? F_SCAN : F_PUSH;
                end
            end
            F_SCAN: begin
                if (r_idx == 3'(NUM_SYMS - 1)) begin
                    n_state = F_EVAL;
                end
            end
            F_EVAL: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_item.valid) begin
            r_item            <= i_item.data;
            r_cmd.op          <= t_opcode'(i_item.data.opcode);
            r_cmd.byte_address <= i_item.data.byte_address;
            r_cmd.byte_value  <= i_item.data.byte_value;
            r_cmd.load_low    <= i_item.data.load_low;
            r_cmd.load_high   <= i_item.data.load_high;
            r_cmd.load_code   <= i_item.data.load_code;
            r_cmd.load_position <= i_item.data.load_position;
            r_cmd.freqs       <= '0;
            r_cmd.cls         <= ST_OK;
            r_idx             <= 3'd0;
            r_acc             <= '0;
            r_fsum            <= '0;
            r_win             <= 3'd0;
            r_win_bits        <= 32'd0;
            r_bad             <= 1'b0;
        end
        if (r_state == F_SCAN) begin
            r_idx         <= r_idx + 3'd1;
            r_acc         <= r_acc + term;
            r_freq[r_idx] <= freq_now;
            r_fsum        <= r_fsum + 35'(freq_now);
            if (bad_now) begin
                r_bad <= 1'b1;
            end
            if (bits > r_win_bits) begin
                r_win      <= r_idx;
                r_win_bits <= bits;
            end
        end
        if (r_state == F_EVAL) begin
            r_cmd.freqs <= freqs_fix;
            if (acc_bad) begin
                r_cmd.cls <= ST_PROB;
            end else if (adj_bad || other_bad) begin
                r_cmd.cls <= ST_FREQ;
            end else begin
                r_cmd.cls <= ST_OK;
            end
        end
    end

    assign i_item.ready = (r_state == F_IDLE);
    assign o_push       = (r_state == F_PUSH) && !i_full;
    assign o_cmd        = r_cmd;

endmodule

>>> src/fsad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsad_queue: command queue between front and back
// Small FIFO of classified items so that each side stalls on its own.
// ----------------------------------------------------------------------------
module fsad_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fsad_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output fsad_pkg::t_cmd o_data,
    output logic           o_empty
);
    import fsad_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

endmodule

>>> src/fsad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsad_back: decoder state, payload store and symbol search
// Carries out classified items: byte writes, state loads and reads, and the
// symbol search and renormalization of a decode, into an output register.
// ----------------------------------------------------------------------------
module fsad_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [12:0]    i_cfg_data,
    input  logic           i_empty,
    input  fsad_pkg::t_cmd i_cmd,
    output logic           o_pop,
    fsad_out_if.source     o_result
);
    import fsad_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_EXEC = 6'b000010,
        B_MUL  = 6'b000100,
        B_ACC  = 6'b001000,
        B_REN  = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    t_bstate     r_state, n_state;
    t_cmd        r_cmd;
    logic [12:0] r_size;
    logic [62:0] r_low, r_high, r_code;
    logic [62:0] n_low, n_high, n_code;
    logic [31:0] r_pos, n_pos;
    logic [63:0] r_width, r_lower, r_p1;
    logic [62:0] r_off, r_p2;
    logic [31:0] r_cum;
    logic [2:0]  r_sym;
    logic [2:0]  r_res_sym, n_res_sym;
    t_status     r_res_status, n_res_status;
    logic [7:0]  r_mem [PAYLOAD_BYTES];
    logic [7:0]  r_rd_data;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        state_bad;
    logic        load_bad;
    logic        mem_we;
    logic [31:0] wr_addr;
    logic [31:0] cum_next;
    logic [64:0] p1_full;
    logic [62:0] p2_full;
    logic [63:0] upper;
    logic        hit;
    logic        e1, e2, e3;
    logic [62:0] off;
    logic [62:0] lo_d, hi_d, cd_d;
    logic        byte_ok;
    logic        bit_in;
    logic        out_load;

    // checks and datapath terms
    always_comb begin
        state_bad = (r_size == 13'd0) || (r_low > r_code) || (r_code > r_high);
        load_bad  = (r_cmd.load_low > r_cmd.load_code) || (r_cmd.load_code > r_cmd.load_high);
        wr_addr   = 32'(r_cmd.byte_address);
        mem_we    = (r_state == B_EXEC) && (r_cmd.op == OP_WRITE)
                    && (wr_addr < 32'(PAYLOAD_BYTES));
        cum_next  = r_cum + 32'(r_cmd.freqs[r_sym]);
        p1_full   = {32'd0, r_width[63:31]} * {33'd0, cum_next};
        p2_full   = {32'd0, r_width[30:0]} * {31'd0, cum_next};
        upper     = r_p1 + 64'(r_p2[62:31]);
        hit       = {1'b0, r_off} < upper;
        e1        = !r_high[62];
        e2        = r_low[62];
        e3        = (r_low[62:61] == 2'b01) && (r_high[62:61] == 2'b10);
        off       = e1 ? 63'd0 : (e2 ? HALF : QUARTER);
        lo_d      = r_low - off;
        hi_d      = r_high - off;
        cd_d      = r_code - off;
        byte_ok   = (32'(r_pos[31:3]) < 32'(r_size))
                    && (32'(r_pos[31:3]) < 32'(PAYLOAD_BYTES));
        bit_in    = byte_ok && r_rd_data[~r_pos[2:0]];
        out_load  = (r_state == B_OUT) && (!r_out_valid || o_result.ready);
    end

    // sequencer and state update
    always_comb begin
        n_state      = r_state;
        n_low        = r_low;
        n_high       = r_high;
        n_code       = r_code;
        n_pos        = r_pos;
        n_res_sym    = r_res_sym;
        n_res_status = r_res_status;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                n_res_sym    = 3'd0;
                n_res_status = ST_OK;
                n_state      = B_OUT;
                case (r_cmd.op)
                    OP_LOAD: begin
                        if (load_bad) begin
                            n_res_status = ST_STATE;
                        end else begin
                            n_low  = r_cmd.load_low;
                            n_high = r_cmd.load_high;
                            n_code = r_cmd.load_code;
                            n_pos  = r_cmd.load_position;
                        end
                    end
                    OP_DECODE: begin
                        if (state_bad) begin
                            n_res_status = ST_STATE;
                        end else if (r_cmd.cls != ST_OK) begin
                            n_res_status = r_cmd.cls;
                        end else begin
                            n_state = B_MUL;
                        end
                    end
                    default: ;
                endcase
            end
            B_MUL: n_state = B_ACC;
            B_ACC: begin
                if (hit) begin
                    if (upper <= r_lower) begin
                        n_res_status = ST_INTERVAL;
                        n_state      = B_OUT;
                    end else begin
                        n_high  = r_low + upper[62:0] - 63'd1;
                        n_low   = r_low + r_lower[62:0];
                        n_state = B_REN;
                    end
                end else if (r_sym == 3'(NUM_SYMS - 1)) begin
                    n_res_status = ST_INTERVAL;
                    n_state      = B_OUT;
                end else begin
                    n_state = B_MUL;
                end
            end
            B_REN: begin
                if (e1 || e2 || e3) begin
                    n_low  = {lo_d[61:0], 1'b0};
                    n_high = {hi_d[61:0], 1'b1};
                    n_code = {cd_d[61:0], bit_in};
                    n_pos  = (r_pos != 32'hFFFF_FFFF) ? r_pos + 32'd1 : r_pos;
                end else begin
                    n_res_sym = r_sym;
                    n_state   = B_OUT;
                end
            end
            B_OUT: begin
                if (out_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_size      <= 13'd0;
            r_low       <= 63'd0;
            r_high      <= TOP;
            r_code      <= 63'd0;
            r_pos       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
            r_code  <= n_code;
            r_pos   <= n_pos;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers of the symbol search
    always_ff @(posedge i_clk) begin
        r_res_sym    <= n_res_sym;
        r_res_status <= n_res_status;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == B_EXEC) begin
            r_width <= 64'(r_high) - 64'(r_low) + 64'd1;
            r_off   <= r_code - r_low;
            r_cum   <= 32'd0;
            r_lower <= 64'd0;
            r_sym   <= 3'd0;
        end
        if (r_state == B_MUL) begin
            r_cum <= cum_next;
            r_p1  <= p1_full[63:0];
            r_p2  <= p2_full;
        end
        if (r_state == B_ACC && !hit) begin
            r_lower <= upper;
            r_sym   <= r_sym + 3'd1;
        end
        if (out_load) begin
            r_out.symbol         <= r_res_sym;
            r_out.status         <= r_res_status;
            r_out.state_low      <= r_low;
            r_out.state_high     <= r_high;
            r_out.state_code     <= r_code;
            r_out.state_position <= r_pos;
        end
    end

    // payload store: read follows the next bit position
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr[PAYLOAD_AW-1:0]] <= r_cmd.byte_value;
        end
        r_rd_data <= r_mem[n_pos[PAYLOAD_AW+2:3]];
    end

    assign o_pop          = (r_state == B_IDLE) && !i_empty;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

`ifndef SYNTHESIS
    a_code_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low <= r_code) && (r_code <= r_high))
        else $error("code window left the interval");

    // a one-point subinterval enters renormalization with low equal to high
    a_renorm_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_REN) |-> (r_low <= r_high))
        else $error("renormalization on an empty interval");

    a_symbol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL || r_state == B_ACC) |-> (r_sym < 3'(NUM_SYMS)))
        else $error("symbol search ran past the alphabet");
`endif

endmodule

>>> src/five_symbol_arithmetic_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_symbol_arithmetic_decoder: 63-bit five-symbol arithmetic decoder
// Front classifies items and builds frequencies, a two-item queue decouples
// it from the back, which holds the decoder state and the payload store.
//
//   channel    dir  handshake       payload
//   i_item     in   valid/ready     t_in_item (opcode, byte, probs, load)
//   o_result   out  valid/ready     t_out_item (symbol, status, state)
//   i_cfg_*    in   write enable    payload_size, 13 bits
//
// Front: a write/load/read item goes straight to the queue; a decode feeds one probability
// a cycle through the exact-sum adder, then evaluation.
// Back: a non-decode item executes and outputs; a decode tries each symbol in turn
// (multiply, then add and compare) and then renormalizes bit by bit.
// Reset is synchronous; there is no clearing pass. A stalled result holds
// the back, the full queue then holds the front.
// ----------------------------------------------------------------------------
module five_symbol_arithmetic_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    fsad_in_if.sink     i_item,
    fsad_out_if.source  o_result
);
    import fsad_pkg::*;

    logic push, pop, full, empty;
    t_cmd push_cmd, pop_cmd;

    fsad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    fsad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    fsad_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_empty    (empty),
        .i_cmd      (pop_cmd),
        .o_pop      (pop),
        .o_result   (o_result)
    );

endmodule
